// ===== hdl/indexed_insert_list_assert.svh =====
// Assertion macros for the checker file.
`ifndef INDEXED_INSERT_LIST_ASSERT_SVH
`define INDEXED_INSERT_LIST_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IIL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed_insert_list assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IIL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed_insert_list assertion failed");

`endif

// ===== hdl/iil_pkg.sv =====
package iil_pkg;

  // Fixed field widths of the channels
  localparam int CMD_W = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int LEN_W = 5;

  // Operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2
  } iil_cmd_t;

  // Per-cell control: load the new value, or take the left neighbor's data
  typedef struct packed {
    logic load;
    logic shift;
  } iil_cell_ctrl_t;

endpackage

// ===== hdl/indexed_insert_list.sv =====
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | in_cmd, in_position, in_value
// out     | out_valid / out_ready| out_ok, out_read_value, out_length
//
// The whole row of cells shifts in parallel on an insert, so a new item is
// taken each cycle while the output register is empty or being drained.
// Results appear in the cycle after the input transfer. Reset clears the
// entry count and the output valid; cell contents stay undefined until
// written. A stalled output holds its result and blocks input.
module indexed_insert_list import iil_pkg::*; #(
  parameter int MAX_ENTRIES = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_ok,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic [LEN_W-1:0]        out_length
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r;
  logic                  out_ok_r, out_ok_nxt;
  logic [VAL_W-1:0]      out_rd_r, out_rd_nxt;
  logic [LEN_W-1:0]      out_len_r;

  logic                  take;
  logic                  full;
  logic [CMP_W-1:0]      pos_x, cnt_x, tgt_x;
  logic                  wr_en, ins_en;
  logic [DATA_WIDTH-1:0] new_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [63:0]           rd_wide;
  iil_cmd_t              cmd;

  logic [DATA_WIDTH-1:0] cell_q [MAX_ENTRIES];
  iil_cell_ctrl_t        cell_ctrl [MAX_ENTRIES];

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(MAX_ENTRIES));
  assign pos_x    = CMP_W'(in_position);
  assign cnt_x    = CMP_W'(count_r);
  assign new_data = DATA_WIDTH'($unsigned(in_value));
  assign cmd      = iil_cmd_t'(in_cmd);

  // Read port over the cells; only used when position is below the count
  assign rd_data = cell_q[pos_x[IDX_W-1:0]];
  assign rd_wide = 64'(rd_data);

  // Decode the operation and its bounds checks
  always_comb begin
    wr_en      = 1'b0;
    ins_en     = 1'b0;
    tgt_x      = cnt_x;
    out_ok_nxt = 1'b0;
    out_rd_nxt = '0;
    count_nxt  = count_r;
    unique case (cmd)
      CMD_APPEND: begin
        if (!full) begin
          wr_en      = 1'b1;
          out_ok_nxt = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        tgt_x = pos_x;
        if (pos_x <= cnt_x && !full) begin
          wr_en      = 1'b1;
          ins_en     = 1'b1;
          out_ok_nxt = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_x < cnt_x) begin
          out_ok_nxt = 1'b1;
          out_rd_nxt = rd_wide[VAL_W-1:0];
        end
      end
      default: begin
        out_ok_nxt = 1'b0;
      end
    endcase
  end

  // Row of cells; each cell above the insert position takes its left neighbor's entry on an insert
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;

    if (i == 0) begin : g_head
      assign left_data = '0;
    end else begin : g_body
      assign left_data = cell_q[i-1];
    end

    assign cell_ctrl[i].load  = take && wr_en && (CMP_W'(i) == tgt_x);
    assign cell_ctrl[i].shift = take && ins_en && (CMP_W'(i) > tgt_x);

    iil_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .load_data (new_data),
      .shift_data(left_data),
      .data      (cell_q[i])
    );
  end

  // Count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        count_r <= count_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_ok_r  <= out_ok_nxt;
      out_rd_r  <= out_rd_nxt;
      out_len_r <= LEN_W'(count_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = $signed(out_rd_r);
  assign out_length     = out_len_r;

endmodule

// ===== hdl/iil_cell.sv =====
module iil_cell import iil_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  iil_cell_ctrl_t        ctrl,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] shift_data,
  output logic [DATA_WIDTH-1:0] data
);

  logic [DATA_WIDTH-1:0] data_r;

  // Entry storage: a new value wins over a shift from the left neighbor
  always_ff @(posedge clk) begin
    priority if (ctrl.load) begin
      data_r <= load_data;
    end else if (ctrl.shift) begin
      data_r <= shift_data;
    end else begin
      data_r <= data_r;
    end
  end

  assign data = data_r;

endmodule

// ===== hdl/indexed_insert_list_chk.sv =====
`include "indexed_insert_list_assert.svh"

module indexed_insert_list_chk import iil_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_ok,
  input logic signed [VAL_W-1:0] out_read_value,
  input logic [LEN_W-1:0]        out_length
);

  // Whole result payload, for hold checks
  logic [VAL_W+LEN_W:0] out_payload;

  assign out_payload = {out_ok, out_read_value, out_length};

  // A stalled result holds
  `IIL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))

  // Every input transfer yields a result in the next cycle
  `IIL_ASSERT_NEXT(a_in_to_out, in_valid && in_ready, out_valid)

  // A refused operation reports a zero read value
  `IIL_ASSERT_NOW(a_refused_zero, out_valid && !out_ok, out_read_value == 0)

  // An empty output register never blocks input
  `IIL_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

endmodule

bind indexed_insert_list indexed_insert_list_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_ok        (out_ok),
  .out_read_value(out_read_value),
  .out_length    (out_length)
);

// ===== tb/indexed_insert_list_tb.sv =====
`timescale 1ns / 1ps

module indexed_insert_list_tb;
  import iil_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int DATA_BITS = 32;
  // Command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_OPS = 900;

  // One result transfer as the list should report it
  typedef struct {
    logic ok;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
  } list_result_t;

  // Shadow copy of the list plus the queue of results still owed by the block
  class list_scoreboard;
    logic signed [VAL_W-1:0] entries [LIST_DEPTH];
    int unsigned count;
    list_result_t expected_results [$];
    int errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Apply one accepted operation to the shadow list and queue its result
    function void note_op(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                          logic signed [VAL_W-1:0] val);
      list_result_t res;
      int p;
      res.ok = 1'b0;
      res.read_value = '0;
      case (cmd)
        CMD_APPEND: begin
          if (count < LIST_DEPTH) begin
            entries[count] = val;
            count++;
            res.ok = 1'b1;
          end
        end
        CMD_INSERT: begin
          // later entries move up one place
          if (pos <= count && count < LIST_DEPTH) begin
            for (p = count; p > pos; p--) entries[p] = entries[p-1];
            entries[pos] = val;
            count++;
            res.ok = 1'b1;
          end
        end
        CMD_READ: begin
          if (pos < count) begin
            res.read_value = entries[pos];
            res.ok = 1'b1;
          end
        end
        default: ;
      endcase
      res.length = count[LEN_W-1:0];
      expected_results.push_back(res);
    endfunction

    // Compare a result transfer with the oldest outstanding result
    function void check_result(logic ok, logic signed [VAL_W-1:0] rd, logic [LEN_W-1:0] len);
      list_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing outstanding: ok=%0d read_value=%0h length=%0d",
               ok, rd, len);
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (ok !== exp_res.ok) begin
        $error("out_ok: expected %0d, got %0d", exp_res.ok, ok);
        errors++;
      end
      if (rd !== exp_res.read_value) begin
        $error("out_read_value: expected %0h, got %0h", exp_res.read_value, rd);
        errors++;
      end
      if (len !== exp_res.length) begin
        $error("out_length: expected %0d, got %0d", exp_res.length, len);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_cmd = CMD_APPEND;
  logic [POS_W-1:0] in_position = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic signed [VAL_W-1:0] out_read_value;
  logic [LEN_W-1:0] out_length;

  list_scoreboard sb;
  int burst_left = 0;
  logic [15:0] ready_pattern = 16'hFFFF;
  int pattern_age = 0;

  indexed_insert_list #(
    .MAX_ENTRIES(LIST_DEPTH),
    .DATA_WIDTH (DATA_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ok        (out_ok),
    .out_read_value(out_read_value),
    .out_length    (out_length)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: rotate a stall pattern, pick a fresh one now and then
  always @(negedge clk) begin
    out_ready <= ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    pattern_age++;
    if (pattern_age == 48) begin
      pattern_age = 0;
      ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
    end
  end

  // Monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_ok, out_read_value, out_length);
      if (in_valid && in_ready) sb.note_op(in_cmd, in_position, in_value);
    end
  end

  // Present one operation (called right after a falling edge), hold until transfer
  task automatic drive_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                          input logic signed [VAL_W-1:0] val);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_position <= pos;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic directed_op(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic signed [VAL_W-1:0] val);
    @(negedge clk);
    drive_op(cmd, pos, val);
  endtask

  // Sender bursts: after each burst drop valid for a random gap
  task automatic pace();
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random operation, weighted toward well-formed writes and in-range reads
  task automatic random_op();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 30)
      drive_op(CMD_INSERT, POS_W'($urandom_range(0, sb.count)), pick_value());
    else if (kind < 45)
      drive_op(CMD_APPEND, POS_W'($urandom_range(0, 31)), pick_value());
    else if (kind < 85 && sb.count > 0)
      drive_op(CMD_READ, POS_W'($urandom_range(0, sb.count - 1)), pick_value());
    else if (kind < 91)
      drive_op(CMD_INSERT, POS_W'($urandom_range(0, 31)), pick_value());
    else if (kind < 97)
      drive_op(CMD_READ, POS_W'($urandom_range(0, 31)), pick_value());
    else
      drive_op(CMD_UNUSED, POS_W'($urandom_range(0, 31)), pick_value());
  endtask

  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, bounds, positions of insert, unused command
    directed_op(CMD_READ, 5'd0, 32'h1234_5678);
    directed_op(CMD_INSERT, 5'd1, 32'd1);
    directed_op(CMD_INSERT, 5'd0, 32'h8000_0000);
    directed_op(CMD_APPEND, 5'd31, 32'h7FFF_FFFF);
    directed_op(CMD_INSERT, 5'd2, 32'hFFFF_FFFF);
    directed_op(CMD_INSERT, 5'd1, 32'h0000_0000);
    directed_op(CMD_INSERT, 5'd0, 32'h5A5A_5A5A);
    directed_op(CMD_READ, 5'd0, 32'h0);
    directed_op(CMD_READ, 5'd1, 32'h0);
    directed_op(CMD_READ, 5'd2, 32'hFFFF_FFFF);
    directed_op(CMD_READ, 5'd3, 32'h0);
    directed_op(CMD_READ, 5'd4, 32'h0);
    directed_op(CMD_READ, 5'd5, 32'h0);
    directed_op(CMD_READ, 5'd31, 32'h0);
    directed_op(CMD_INSERT, 5'd31, 32'hA5A5_A5A5);
    directed_op(CMD_INSERT, 5'd6, 32'h0000_0001);
    directed_op(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF);
    directed_op(CMD_UNUSED, 5'd0, 32'h0);

    // Random part; list fills early, then full-list refusals and reads dominate
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 2) begin
        // hold off until the block has delivered everything
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      pace();
      random_op();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
